// File: design/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions of the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  // Input item codes
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  // Datapath commands from the controller
  typedef struct packed {
    logic       load_byte;   // write byte into the block buffer
    logic [1:0] byte_src;    // which byte to write
    logic [2:0] len_sel;     // length byte, most significant first
    logic       count_byte;  // advance the message length
    logic       comp_start;  // load working vars from hash words
    logic       comp_round;  // run one round
    logic       comp_final;  // add working vars into hash words
    logic       restart;     // reload initial hash, clear length
  } sha_cmd_t;

  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_PAD  = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  typedef struct packed {
    logic [5:0] fill_count;
    logic [5:0] round;
  } sha_status_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
    rotr = (x >> r) | (x << (32 - r));
  endfunction

endpackage

// File: design/sha256_dp.sv
// ----------------------------------------------------------------------------
// sha256_dp
// Block buffer, rolling schedule, round unit and hash words. One round a cycle.
// ----------------------------------------------------------------------------
module sha256_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  sha256_pkg::sha_cmd_t    cmd,
  input  logic [7:0]              data_byte,
  input  logic [2:0]              word_sel,
  output sha256_pkg::sha_status_t status,
  output logic [31:0]             digest_word
);
  import sha256_pkg::*;

  logic [31:0] block_words [16];
  logic [31:0] sched [16];
  logic [31:0] hash  [8];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [5:0]  fill_count;
  logic [5:0]  round;
  logic [60:0] byte_total;
  logic [63:0] bit_len;
  logic [7:0]  wr_byte;
  logic [31:0] w, w15, w2, s0, s1, t1, t2, new_w;
  logic        first16;

  assign bit_len = {byte_total, 3'b000};

  // Select byte to store
  always_comb begin
    case (cmd.byte_src)
      SRC_DATA: wr_byte = data_byte;
      SRC_PAD:  wr_byte = PAD_BYTE;
      SRC_ZERO: wr_byte = 8'h00;
      SRC_LEN:  wr_byte = bit_len[{~cmd.len_sel, 3'b000} +: 8];
      default:  wr_byte = 8'h00;
    endcase
  end

  // Schedule word and round functions; schedule is a 16-deep shift line
  assign first16 = (round < 6'd16);
  assign w15 = sched[1];
  assign w2  = sched[14];
  assign s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
  assign s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
  assign new_w = sched[0] + s0 + sched[9] + s1;
  assign w   = first16 ? block_words[round[3:0]] : new_w;
  assign t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + ROUND_K[round] + w;
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));

  // Control-visible counters and hash words
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      fill_count <= '0;
      byte_total <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= START_HASH[i];
    end else begin
      if (cmd.load_byte) fill_count <= fill_count + 6'd1;
      if (cmd.count_byte) byte_total <= byte_total + 61'd1;
      if (cmd.comp_final) begin
        hash[0] <= hash[0] + a; hash[1] <= hash[1] + b;
        hash[2] <= hash[2] + c; hash[3] <= hash[3] + d;
        hash[4] <= hash[4] + e; hash[5] <= hash[5] + f;
        hash[6] <= hash[6] + g; hash[7] <= hash[7] + h;
      end
    end
    if (rst) round <= '0;
    else if (cmd.comp_start) round <= '0;
    else if (cmd.comp_round) round <= round + 6'd1;
  end

  // Payload: buffer (big-endian byte lanes), schedule, working variables
  always_ff @(posedge clk) begin
    if (cmd.load_byte)
      block_words[fill_count[5:2]][{~fill_count[1:0], 3'b000} +: 8] <= wr_byte;
    if (cmd.comp_start) begin
      a <= hash[0]; b <= hash[1]; c <= hash[2]; d <= hash[3];
      e <= hash[4]; f <= hash[5]; g <= hash[6]; h <= hash[7];
    end else if (cmd.comp_round) begin
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
      for (int i = 0; i < 15; i++) sched[i] <= sched[i+1];
      sched[15] <= w;
    end
  end

  assign status.fill_count = fill_count;
  assign status.round      = round;
  assign digest_word       = hash[word_sel];

endmodule

// File: design/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer: byte intake, padding, 64-round compression and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    kind,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [2:0]              word_sel,
  output sha256_pkg::sha_cmd_t    cmd,
  input  sha256_pkg::sha_status_t status
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LEN, ST_START, ST_ROUND, ST_FINAL, ST_OUT
  } state_t;

  state_t     state;
  logic       finishing;  // compression is part of the padding
  logic       len_done;   // length written, digest follows compression
  logic [2:0] len_idx;
  logic       take;

  assign in_ready  = (state == ST_IDLE);
  assign take      = in_valid && in_ready;
  assign out_valid = (state == ST_OUT);

  // Command decode
  always_comb begin
    cmd = '0;
    cmd.len_sel = len_idx;
    case (state)
      ST_IDLE: begin
        cmd.load_byte  = take;
        cmd.byte_src   = (kind == KIND_BYTE) ? SRC_DATA : SRC_PAD;
        cmd.count_byte = take && (kind == KIND_BYTE);
      end
      ST_PAD: begin
        cmd.load_byte = (status.fill_count != LEN_OFFSET);
        cmd.byte_src  = SRC_ZERO;
      end
      ST_LEN: begin
        cmd.load_byte = 1'b1;
        cmd.byte_src  = SRC_LEN;
      end
      ST_START: cmd.comp_start = 1'b1;
      ST_ROUND: cmd.comp_round = 1'b1;
      ST_FINAL: cmd.comp_final = 1'b1;
      ST_OUT:   cmd.restart    = out_ready && (word_sel == 3'd7);
      default:  cmd = '0;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      finishing <= 1'b0;
      len_done  <= 1'b0;
      len_idx   <= '0;
      word_sel  <= '0;
    end else begin
      case (state)
        ST_IDLE: if (take) begin
          finishing <= (kind == KIND_FINISH);
          len_done  <= 1'b0;
          len_idx   <= '0;
          if (status.fill_count == 6'd63) state <= ST_START;
          else if (kind == KIND_FINISH) state <= ST_PAD;
        end
        ST_PAD: begin
          if (status.fill_count == LEN_OFFSET) state <= ST_LEN;
          else if (status.fill_count == 6'd63) state <= ST_START;
        end
        ST_LEN: begin
          len_idx <= len_idx + 3'd1;
          if (len_idx == 3'd7) begin
            len_done <= 1'b1;
            state    <= ST_START;
          end
        end
        ST_START: state <= ST_ROUND;
        ST_ROUND: if (status.round == 6'd63) state <= ST_FINAL;
        ST_FINAL: begin
          if (len_done) begin
            word_sel <= '0;
            state    <= ST_OUT;
          end else if (finishing) state <= ST_PAD;
          else state <= ST_IDLE;
        end
        ST_OUT: if (out_ready) begin
          word_sel <= word_sel + 3'd1;
          if (word_sel == 3'd7) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: design/sha256_byte_stream_hasher_core.sv
// Sequence: bytes are taken only while idle, not during padding, compression
// or output. A byte that fills the block starts a compression (one load, 64
// rounds, one hash update). A finish adds the pad byte, zero bytes to offset 56,
// a turnaround, 8 length bytes, a compression per block (one or two), 8 words.
// Reset: synchronous; hash words return to the initial values, counts clear.
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core
// Byte-stream SHA-256 hasher: controller plus datapath.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha256_pkg::*;

  sha_cmd_t    cmd;
  sha_status_t status;
  logic [2:0]  word_sel;

  sha256_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .kind, .out_ready, .out_valid,
    .word_sel, .cmd, .status
  );

  sha256_dp u_dp (
    .clk, .rst, .cmd, .data_byte, .word_sel, .status, .digest_word
  );

  assign word_index = word_sel;
  assign last_word  = (word_sel == 3'd7);

endmodule

// File: design/sha256_checker.sv
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks on the hasher's output sequence.
// ----------------------------------------------------------------------------
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  word_index,
  input logic        last_word
);
  // No input taken while the digest is shown
  a_excl: assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input ready during digest output");
  // Last flag marks word seven only
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word mismatch");
  // Index advances after a taken word
  a_adv: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=> out_valid && word_index == $past(word_index) + 3'd1)
    else $error("word index skipped");
  // Word stays while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_index))
    else $error("output changed while stalled");
endmodule

bind sha256_byte_stream_hasher_core sha256_checker u_checker (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .word_index, .last_word
);
